@@ sv/dowc_pkg.sv @@
package dowc_pkg;

  // Largest result year that is reported as in range.
  localparam int MaxYear = 9999;

  // The working year must hold the start year plus or minus the span of the offset.
  localparam int YearW = 17;

  // Length of the Gregorian cycle in years; the weekday and the leap rule repeat with it.
  localparam int YearCycle = 400;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusBadDate = 2'd1;
  localparam logic [1:0] StatusRange   = 2'd2;

  typedef struct packed {
    logic [4:0]         in_day;
    logic [3:0]         in_month;
    logic [13:0]        in_year;
    logic signed [15:0] day_offset;
  } req_t;

  typedef struct packed {
    logic [4:0]  out_day;
    logic [3:0]  out_month;
    logic [13:0] out_year;
    logic [2:0]  weekday;
    logic [1:0]  status;
  } rsp_t;

  // The year residue modulo 400 carries everything the leap rule needs.
  function automatic logic is_leap(input logic [8:0] res);
    return (res[1:0] == 2'b00) && (res != 9'd100) && (res != 9'd200) && (res != 9'd300);
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic leap);
    logic [4:0] n;
    case (m)
      4'd2:  n = leap ? 5'd29 : 5'd28;
      4'd4:  n = 5'd30;
      4'd6:  n = 5'd30;
      4'd9:  n = 5'd30;
      4'd11: n = 5'd30;
      default: n = 5'd31;
    endcase
    return n;
  endfunction

  // Month term of the weekday formula, (13 * (m + 1)) / 5, for March (3) to February (14).
  function automatic logic [5:0] month_term(input logic [3:0] mz);
    logic [5:0] t;
    case (mz)
      4'd3:  t = 6'd10;
      4'd4:  t = 6'd13;
      4'd5:  t = 6'd15;
      4'd6:  t = 6'd18;
      4'd7:  t = 6'd20;
      4'd8:  t = 6'd23;
      4'd9:  t = 6'd26;
      4'd10: t = 6'd28;
      4'd11: t = 6'd31;
      4'd12: t = 6'd33;
      4'd13: t = 6'd36;
      4'd14: t = 6'd39;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

  // Non-negative weekday sum before the final reduction modulo 7. Century terms only
  // matter modulo 400 years, since whole four-century groups add a multiple of 7. The
  // year before year zero uses truncating division: year term -1, century terms zero.
  function automatic logic [7:0] zeller_sum(input logic [4:0] d, input logic [3:0] m,
                                            input logic [8:0] res, input logic yzero);
    logic       early;
    logic [3:0] mz;
    logic [8:0] rz;
    logic [1:0] jr;
    logic [8:0] k;
    logic [8:0] s;
    early = (m < 4'd3);
    mz    = early ? m + 4'd12 : m;
    rz    = res;
    if (early) begin
      rz = (res == 9'd0) ? 9'(YearCycle - 1) : res - 9'd1;
    end
    if (rz >= 9'd300) begin
      jr = 2'd3;
      k  = rz - 9'd300;
    end else if (rz >= 9'd200) begin
      jr = 2'd2;
      k  = rz - 9'd200;
    end else if (rz >= 9'd100) begin
      jr = 2'd1;
      k  = rz - 9'd100;
    end else begin
      jr = 2'd0;
      k  = rz;
    end
    s = {4'b0, d} + {3'b0, month_term(mz)};
    if (early && yzero) begin
      s = s - 9'd1;
    end else begin
      s = s + k + {2'b0, k[8:2]} - {6'b0, jr, 1'b0};
    end
    return s[7:0];
  endfunction

endpackage

@@ sv/dowc_alu.sv @@
module dowc_alu (
  input  logic [15:0] a_i,
  input  logic [15:0] b_i,
  output logic [15:0] diff_o,
  output logic        ge_o
);

  logic [16:0] full;

  // The borrow out of the subtraction doubles as the compare result.
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[15:0];
  assign ge_o   = ~full[16];

endmodule

@@ sv/dowc_seq.sv @@
module dowc_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  dowc_pkg::req_t   req_i,
  input  logic             out_free_i,
  output logic             busy_o,
  output logic             done_o,
  output dowc_pkg::rsp_t   rsp_o
);

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SMod   = 3'd1;
  localparam logic [2:0] SCheck = 3'd2;
  localparam logic [2:0] SStep  = 3'd3;
  localparam logic [2:0] SZsum  = 3'd4;
  localparam logic [2:0] SMod7  = 3'd5;
  localparam logic [2:0] SDone  = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] status_q, status_d;

  dowc_pkg::req_t                   req_q, req_d;
  logic [4:0]                       d_q, d_d;
  logic [3:0]                       m_q, m_d;
  logic signed [dowc_pkg::YearW-1:0] yr_q, yr_d;
  logic [13:0]                      res_q, res_d;
  logic [15:0]                      left_q, left_d;
  logic                             neg_q, neg_d;

  logic [15:0] alu_a, alu_b, alu_diff;
  logic        alu_ge;
  logic        leap;
  logic [4:0]  dim, dim_prev;
  logic [3:0]  m_prev;
  logic [5:0]  rest;
  logic        out_of_range;

  assign leap     = dowc_pkg::is_leap(res_q[8:0]);
  assign dim      = dowc_pkg::days_in(m_q, leap);
  assign m_prev   = (m_q == 4'd1) ? 4'd12 : m_q - 4'd1;
  // Only February depends on the year, and stepping into February keeps the year.
  assign dim_prev = dowc_pkg::days_in(m_prev, leap);
  assign rest     = {1'b0, dim} - {1'b0, d_q} + 6'd1;

  assign out_of_range = (yr_q < 0) ||
                        (yr_q > $signed(dowc_pkg::YearW'(dowc_pkg::MaxYear)));

  always_comb begin
    alu_a = left_q;
    alu_b = '0;
    case (state_q)
      SMod: begin
        alu_a = {2'b0, res_q};
        alu_b = 16'(dowc_pkg::YearCycle);
      end
      SStep: begin
        alu_b = neg_q ? {11'b0, d_q} : {10'b0, rest};
      end
      SMod7: begin
        alu_b = 16'd7;
      end
      default: begin
      end
    endcase
  end

  dowc_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    req_d    = req_q;
    d_d      = d_q;
    m_d      = m_q;
    yr_d     = yr_q;
    res_d    = res_q;
    left_d   = left_q;
    neg_d    = neg_q;
    done_o   = 1'b0;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          req_d    = req_i;
          d_d      = req_i.in_day;
          m_d      = req_i.in_month;
          yr_d     = dowc_pkg::YearW'(req_i.in_year);
          res_d    = req_i.in_year;
          neg_d    = req_i.day_offset[15];
          left_d   = req_i.day_offset[15] ? (~req_i.day_offset + 16'd1) : req_i.day_offset;
          status_d = dowc_pkg::StatusOk;
          state_d  = SMod;
        end
      end
      SMod: begin
        if (alu_ge) begin
          res_d = alu_diff[13:0];
        end else begin
          state_d = SCheck;
        end
      end
      SCheck: begin
        if ((m_q >= 4'd1) && (m_q <= 4'd12) && (d_q != 5'd0) && (d_q <= dim)) begin
          state_d = SStep;
        end else begin
          status_d = dowc_pkg::StatusBadDate;
          state_d  = SDone;
        end
      end
      SStep: begin
        if (left_q == 16'd0) begin
          state_d = SZsum;
        end else if (!neg_q) begin
          if (alu_ge) begin
            left_d = alu_diff;
            d_d    = 5'd1;
            if (m_q == 4'd12) begin
              m_d   = 4'd1;
              yr_d  = yr_q + $signed(dowc_pkg::YearW'(1));
              res_d = (res_q == 14'(dowc_pkg::YearCycle - 1)) ? 14'd0 : res_q + 14'd1;
            end else begin
              m_d = m_q + 4'd1;
            end
          end else begin
            d_d    = d_q + left_q[4:0];
            left_d = '0;
          end
        end else begin
          if (alu_ge) begin
            left_d = alu_diff;
            m_d    = m_prev;
            d_d    = dim_prev;
            if (m_q == 4'd1) begin
              yr_d  = yr_q - $signed(dowc_pkg::YearW'(1));
              res_d = (res_q == 14'd0) ? 14'(dowc_pkg::YearCycle - 1) : res_q - 14'd1;
            end
          end else begin
            d_d    = d_q - left_q[4:0];
            left_d = '0;
          end
        end
      end
      SZsum: begin
        if (out_of_range) begin
          status_d = dowc_pkg::StatusRange;
          state_d  = SDone;
        end else begin
          left_d  = {8'b0, dowc_pkg::zeller_sum(d_q, m_q, res_q[8:0], yr_q == 0)};
          state_d = SMod7;
        end
      end
      SMod7: begin
        if (alu_ge) begin
          left_d = alu_diff;
        end else begin
          state_d = SDone;
        end
      end
      SDone: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_comb begin
    if (status_q != dowc_pkg::StatusOk) begin
      rsp_o.out_day   = req_q.in_day;
      rsp_o.out_month = req_q.in_month;
      rsp_o.out_year  = req_q.in_year;
      rsp_o.weekday   = 3'd0;
    end else begin
      rsp_o.out_day   = d_q;
      rsp_o.out_month = m_q;
      rsp_o.out_year  = yr_q[13:0];
      rsp_o.weekday   = left_q[2:0];
    end
    rsp_o.status = status_q;
  end

  assign busy_o = (state_q != SIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      status_q <= dowc_pkg::StatusOk;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    d_q    <= d_d;
    m_q    <= m_d;
    yr_q   <= yr_d;
    res_q  <= res_d;
    left_q <= left_d;
    neg_q  <= neg_d;
  end

endmodule

@@ sv/date_offset_weekday_calc_core.sv @@
// Adds a signed day offset to a Gregorian date and gives the weekday of the result
// (0 Saturday through 6 Friday). A bad start date returns status 1 and a result year
// outside 0 to 9999 returns status 2; in both cases the start date is echoed and the
// weekday is 0. One request is worked at a time on a single shared subtractor: it
// reduces the year modulo 400 by repeated subtraction, checks the date, steps across
// the month boundaries one at a time, and reduces the weekday sum modulo 7. The
// finished result sits in an output register, so the next request is taken while it
// waits to be collected.
module date_offset_weekday_calc_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dowc_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dowc_pkg::rsp_t out_rsp_o
);

  logic           busy;
  logic           start;
  logic           done;
  logic           out_free;
  logic           out_valid_q;
  dowc_pkg::rsp_t rsp;
  dowc_pkg::rsp_t out_rsp_q;

  assign in_stall_o = busy;
  assign start      = in_valid_i && !busy;
  assign out_free   = !out_valid_q || !out_stall_i;

  dowc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .req_i      (in_req_i),
    .out_free_i (out_free),
    .busy_o     (busy),
    .done_o     (done),
    .rsp_o      (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_rsp_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  a_done_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> out_free)
    else $error("result finished while the output register was still occupied");

  a_start_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> in_stall_o)
    else $error("accepted request did not make the block busy");

  a_ok_weekday_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_rsp_q.status == dowc_pkg::StatusOk)) |-> (out_rsp_q.weekday <= 3'd6))
    else $error("weekday out of range on a good result");

  a_err_weekday_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_rsp_q.status != dowc_pkg::StatusOk)) |-> (out_rsp_q.weekday == 3'd0))
    else $error("nonzero weekday on a flagged result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_rsp_q.status == dowc_pkg::StatusOk) ||
                     (out_rsp_q.status == dowc_pkg::StatusBadDate) ||
                     (out_rsp_q.status == dowc_pkg::StatusRange)))
    else $error("undefined status code on the output");

endmodule
